@@ hw/rtl/bcp_pkg.sv @@
// ----------------------------------------------------------------------------
// bcp_pkg
// shared constants and types for the bloom combine pixel core
// ----------------------------------------------------------------------------
package bcp_pkg;

  localparam int CoefFracBitsDef = 8;
  localparam int CfgIdxW         = 2;
  localparam int CfgDataW        = 16;
  localparam int ChFrac          = 12;
  localparam int ChOne           = 4096;
  localparam int ChMax           = 8191;
  localparam int BloomThresh     = 1024;
  localparam int WRed            = 1229;
  localparam int WGreen          = 2417;
  localparam int WBlue           = 450;
  localparam int RecipW          = 17;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BLOOM_GAIN = 2'd0,
    REG_BLOOM_SAT  = 2'd1,
    REG_BASE_GAIN  = 2'd2,
    REG_BASE_SAT   = 2'd3
  } cfg_reg_t;

  // ceil(2^(ChFrac+RecipW) / a) for every alpha, entry 0 unused
  function automatic logic [255:0][29:0] recip_table();
    logic [255:0][29:0] tab;
    tab = '0;
    for (int a = 1; a < 256; a++) begin
      tab[a] = 30'(((64'd1 << (ChFrac + RecipW)) + 64'(a) - 64'd1) / 64'(a));
    end
    return tab;
  endfunction

  localparam logic [255:0][29:0] RecipTab = recip_table();

endpackage

@@ hw/rtl/bloom_combine_pixel_core.sv @@
// ----------------------------------------------------------------------------
// bloom_combine_pixel_core
// unpremultiply, bloom extract, saturation and gain, darken, premultiply
// ----------------------------------------------------------------------------
// channel  ports                               handshake
// input    in_alpha/red/green/blue             start & !busy
// result   out_alpha/red/green/blue            out_valid strobe, one cycle
// config   cfg_we, cfg_idx, cfg_data           cfg_we
//
// one pixel per clock; start reaches out_valid through the valid shift register vld_r
// busy is tied low, the pipeline never stalls
// reset clears the valid bits and sets all gains and saturations to 256
// ----------------------------------------------------------------------------
module bloom_combine_pixel_core #(
  parameter int COEF_FRAC_BITS = bcp_pkg::CoefFracBitsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    in_alpha,
  input  logic [7:0]                    in_red,
  input  logic [7:0]                    in_green,
  input  logic [7:0]                    in_blue,
  output logic                          out_valid,
  output logic [7:0]                    out_alpha,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  input  logic                          cfg_we,
  input  logic [bcp_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [bcp_pkg::CfgDataW-1:0]  cfg_data
);
  import bcp_pkg::*;

  localparam int NS = 9;
  localparam logic signed [15:0] RegRst = 16'sd256;

  logic signed [15:0] bloom_gain_r, bloom_sat_r, base_gain_r, base_sat_r;
  logic [NS-1:0]      vld_r;
  logic [7:0]         a_r [NS];

  // stage 1: channels and reciprocal of alpha
  logic [7:0]  c1_r [3];
  logic [29:0] rc1_r;
  // stage 2: product
  logic [37:0] p2_r [3];
  // stage 3: base and bloom
  logic [12:0] base3_r [3];
  logic [12:0] bloom3_r [3];
  // stage 4: grey
  logic signed [14:0] bs4_r [3], bl4_r [3];
  logic signed [14:0] gbs4_r, gbl4_r;
  // stage 5: sat product
  logic signed [31:0] sbs5_r [3], sbl5_r [3];
  logic signed [14:0] gbs5_r, gbl5_r;
  // stage 6: adj
  logic signed [31:0] abs6_r [3], abl6_r [3];
  // stage 7: gain products
  logic signed [47:0] gbs7_r [3], gbl7_r [3];
  // stage 8: darken
  logic signed [47:0] bl8_r [3];
  logic signed [47:0] bsd8_r [3];
  // stage 9 out
  logic [7:0] o9_r [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bloom_gain_r <= RegRst;
      bloom_sat_r  <= RegRst;
      base_gain_r  <= RegRst;
      base_sat_r   <= RegRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_BLOOM_GAIN: bloom_gain_r <= cfg_data;
        REG_BLOOM_SAT:  bloom_sat_r  <= cfg_data;
        REG_BASE_GAIN:  base_gain_r  <= cfg_data;
        REG_BASE_SAT:   base_sat_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[NS-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    a_r[0] <= in_alpha;
    for (int s = 1; s < NS; s++) a_r[s] <= a_r[s-1];
  end

  function automatic logic signed [14:0] grey_f(input logic signed [14:0] x0,
      input logic signed [14:0] x1, input logic signed [14:0] x2);
    logic signed [31:0] s;
    s = 32'(x0) * 32'sd1229 + 32'(x1) * 32'sd2417 + 32'(x2) * 32'sd450;
    return 15'(s >>> ChFrac);
  endfunction

  always_ff @(posedge clk) begin
    logic [25:0] q;
    logic [13:0] t;
    logic [16:0] t4;
    logic [15:0] bq;
    logic [12:0] dk;
    logic signed [47:0] x;
    // stage 1
    c1_r[0] <= in_red;
    c1_r[1] <= in_green;
    c1_r[2] <= in_blue;
    rc1_r   <= RecipTab[in_alpha];
    for (int i = 0; i < 3; i++) begin
      // stage 2
      p2_r[i] <= {8'd0, rc1_r} * {30'd0, c1_r[i]};
      // stage 3
      q = (p2_r[i] >> RecipW) > 38'(ChMax) ? 26'(ChMax) : 26'(p2_r[i] >> RecipW);
      base3_r[i] <= 13'(q);
      if (q <= 26'(BloomThresh)) begin
        bloom3_r[i] <= '0;
      end else begin
        t  = 14'(q - 26'(BloomThresh));
        t4 = {t, 2'b00} + 17'd0;
        // divide by 3 via reciprocal 21846/65536, exact for t4 < 2^15
        bq = 16'(({15'd0, t4} * 32'd21846) >> 16);
        bloom3_r[i] <= bq > 16'(ChOne) ? 13'(ChOne) : 13'(bq);
      end
    end
    // stage 4
    for (int i = 0; i < 3; i++) begin
      bs4_r[i] <= 15'(base3_r[i]);
      bl4_r[i] <= 15'(bloom3_r[i]);
    end
    gbs4_r <= grey_f(15'(base3_r[0]), 15'(base3_r[1]), 15'(base3_r[2]));
    gbl4_r <= grey_f(15'(bloom3_r[0]), 15'(bloom3_r[1]), 15'(bloom3_r[2]));
    // stage 5
    for (int i = 0; i < 3; i++) begin
      sbs5_r[i] <= 32'(base_sat_r) * 32'(bs4_r[i] - gbs4_r);
      sbl5_r[i] <= 32'(bloom_sat_r) * 32'(bl4_r[i] - gbl4_r);
    end
    gbs5_r <= gbs4_r;
    gbl5_r <= gbl4_r;
    // stage 6
    for (int i = 0; i < 3; i++) begin
      abs6_r[i] <= 32'(gbs5_r) + (sbs5_r[i] >>> COEF_FRAC_BITS);
      abl6_r[i] <= 32'(gbl5_r) + (sbl5_r[i] >>> COEF_FRAC_BITS);
    end
    // stage 7
    for (int i = 0; i < 3; i++) begin
      gbs7_r[i] <= (48'(abs6_r[i]) * 48'(base_gain_r)) >>> COEF_FRAC_BITS;
      gbl7_r[i] <= (48'(abl6_r[i]) * 48'(bloom_gain_r)) >>> COEF_FRAC_BITS;
    end
    // stage 8
    for (int i = 0; i < 3; i++) begin
      if (gbl7_r[i] < 0)                dk = 13'(ChOne);
      else if (gbl7_r[i] > 48'(ChOne))  dk = '0;
      else                              dk = 13'(48'(ChOne) - gbl7_r[i]);
      bsd8_r[i] <= (gbs7_r[i] * $signed(48'(dk))) >>> ChFrac;
      bl8_r[i]  <= gbl7_r[i];
    end
    // stage 9
    for (int i = 0; i < 3; i++) begin
      x = ((bsd8_r[i] + bl8_r[i]) * $signed({40'd0, a_r[7]})) >>> ChFrac;
      if (a_r[7] == 8'd0)   o9_r[i] <= '0;
      else if (x < 0)       o9_r[i] <= '0;
      else if (x > 48'sd255) o9_r[i] <= 8'hff;
      else                  o9_r[i] <= 8'(x);
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_alpha = a_r[NS-1];
  assign out_red   = o9_r[0];
  assign out_green = o9_r[1];
  assign out_blue  = o9_r[2];

  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy asserted");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##9 out_valid)
    else $error("result strobe missing");
  a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == 8'd0) |-> (out_red == 8'd0 && out_green == 8'd0
      && out_blue == 8'd0))
    else $error("zero alpha gave colour");
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##9 (out_alpha == $past(in_alpha, 9)))
    else $error("alpha not passed through");

endmodule

@@ tb/sv/bloom_combine_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// bloom_combine_pixel_checker
// watches the request, result and register ports of the bloom combine core,
// works out each pixel in fixed point and compares results field by field
// ----------------------------------------------------------------------------
module bloom_combine_pixel_checker #(
  parameter int COEF_FRAC_BITS = bcp_pkg::CoefFracBitsDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic [7:0]                   in_alpha,
  input  logic [7:0]                   in_red,
  input  logic [7:0]                   in_green,
  input  logic [7:0]                   in_blue,
  input  logic                         out_valid,
  input  logic [7:0]                   out_alpha,
  input  logic [7:0]                   out_red,
  input  logic [7:0]                   out_green,
  input  logic [7:0]                   out_blue,
  input  logic                         cfg_we,
  input  logic [bcp_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [bcp_pkg::CfgDataW-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import bcp_pkg::*;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  pixel_t pixel_q[$];
  longint gain_bloom, sat_bloom, gain_base, sat_base;

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void apply_sat(ref longint ch[3], input longint sat);
    longint grey;
    grey = (WRed * ch[0] + WGreen * ch[1] + WBlue * ch[2]) >>> ChFrac;
    for (int i = 0; i < 3; i++)
      ch[i] = grey + ((sat * (ch[i] - grey)) >>> COEF_FRAC_BITS);
  endfunction

  function automatic pixel_t bloom_pixel(pixel_t p);
    pixel_t o;
    longint al, c, b, t, bl, bs;
    longint base[3], bloom[3];
    al = p.a;
    o = '0;
    if (al == 0) return o;
    for (int i = 0; i < 3; i++) begin
      c = (i == 0) ? p.r : (i == 1) ? p.g : p.b;
      b = clip((c * ChOne) / al, 0, ChMax);
      base[i] = b;
      t = b - BloomThresh;
      bloom[i] = t <= 0 ? 0 : clip(floor_div(t * 4, 3), 0, ChOne);
    end
    apply_sat(bloom, sat_bloom);
    apply_sat(base, sat_base);
    o.a = p.a;
    for (int i = 0; i < 3; i++) begin
      bl = (bloom[i] * gain_bloom) >>> COEF_FRAC_BITS;
      bs = (base[i] * gain_base) >>> COEF_FRAC_BITS;
      bs = (bs * (ChOne - clip(bl, 0, ChOne))) >>> ChFrac;
      c = clip(((bs + bl) * al) >>> ChFrac, 0, 255);
      if (i == 0) o.r = c[7:0];
      else if (i == 1) o.g = c[7:0];
      else o.b = c[7:0];
    end
    return o;
  endfunction

  task automatic report(string field, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  assign pending = pixel_q.size();

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      gain_bloom <= 256;
      sat_bloom  <= 256;
      gain_base  <= 256;
      sat_base   <= 256;
    end else begin
      if (out_valid) begin
        if (pixel_q.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (out_alpha !== want.a) report("alpha", out_alpha, want.a);
          if (out_red   !== want.r) report("red", out_red, want.r);
          if (out_green !== want.g) report("green", out_green, want.g);
          if (out_blue  !== want.b) report("blue", out_blue, want.b);
        end
      end
      if (start && !busy)
        pixel_q.push_back(bloom_pixel('{in_alpha, in_red, in_green, in_blue}));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_BLOOM_GAIN: gain_bloom <= longint'($signed(cfg_data));
          REG_BLOOM_SAT:  sat_bloom  <= longint'($signed(cfg_data));
          REG_BASE_GAIN:  gain_base  <= longint'($signed(cfg_data));
          REG_BASE_SAT:   sat_base   <= longint'($signed(cfg_data));
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/sv/tb_bloom_combine_pixel_core.sv @@
// ----------------------------------------------------------------------------
// tb_bloom_combine_pixel_core
// drives directed and random pixels through the bloom combine core under
// several register settings; the checker predicts and compares each result
// ----------------------------------------------------------------------------
module tb_bloom_combine_pixel_core;
  import bcp_pkg::*;

  localparam int Latency  = 9;
  localparam int WdogMax  = 2000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] in_alpha = '0, in_red = '0, in_green = '0, in_blue = '0;
  logic       out_valid;
  logic [7:0] out_alpha, out_red, out_green, out_blue;
  logic       cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int fail_count, pending, idle_cycles;
  logic calm;

  always #4 clk = ~clk;

  bloom_combine_pixel_core i_dut (.*);
  bloom_combine_pixel_checker i_chk (.*);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogMax) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] a, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!calm && $urandom_range(99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_alpha <= a;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic set_all(logic [15:0] bg, logic [15:0] bsat, logic [15:0] g, logic [15:0] s);
    write_reg(REG_BLOOM_GAIN, bg);
    write_reg(REG_BLOOM_SAT, bsat);
    write_reg(REG_BASE_GAIN, g);
    write_reg(REG_BASE_SAT, s);
    cfg_we <= 1'b0;
  endtask

  task automatic random_pixels(int n);
    logic [7:0] a;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: a = 8'd255;
        1: a = 8'($urandom_range(0, 3));
        default: a = 8'($urandom);
      endcase
      if ($urandom_range(3) == 0)
        send_pixel(a, 8'($urandom), 8'($urandom), 8'($urandom));
      else
        send_pixel(a, 8'($urandom_range(a)), 8'($urandom_range(a)), 8'($urandom_range(a)));
    end
  endtask

  initial begin
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, zero alpha, channels above alpha, bloom threshold
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd64, 8'd63, 8'd65);
    send_pixel(8'd1, 8'd1, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd200, 8'd10, 8'd128);
    send_pixel(8'd170, 8'd85, 8'd170, 8'd42);
    send_pixel(8'd255, 8'd255, 8'd0, 8'd128);
    drain();
    set_all(16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_pixel(8'd255, 8'd255, 8'd0, 8'd128);
    send_pixel(8'd255, 8'd10, 8'd240, 8'd100);
    send_pixel(8'd100, 8'd90, 8'd20, 8'd250);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    random_pixels(300);
    drain();
    set_all(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_pixels(150);
    drain();
    set_all(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    random_pixels(200);
    drain();
    calm = 1'b1;
    set_all(16'h0100, 16'h0100, 16'h0100, 16'h0100);
    random_pixels(400);
    calm = 1'b0;
    drain();
    for (int k = 0; k < 6; k++) begin
      set_all(16'($urandom_range(0, 1024)), 16'($urandom_range(0, 768)),
              16'($urandom_range(0, 1024)) - 16'd256, 16'($urandom));
      random_pixels(150);
      drain();
    end
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
